FILE: rtl/php_pkg.sv
// ----------------------------------------------------------------------------
// Pinhole projection package
// Shared types and constants for the projection / unprojection unit.
// ----------------------------------------------------------------------------
package php_pkg;

  localparam int unsigned WORD_W = 32;
  localparam int unsigned DIV_W  = 64;  // dividend magnitude width
  localparam int unsigned DVS_W  = 32;  // divisor magnitude width

  typedef enum logic [1:0] {
    REG_FOCAL_X  = 2'd0,
    REG_FOCAL_Y  = 2'd1,
    REG_CENTER_X = 2'd2,
    REG_CENTER_Y = 2'd3
  } reg_idx_t;

  // Classified word handed from the front to the back.
  typedef struct packed {
    logic              unproj;   // 1: unprojection
    logic              div_err;  // divisor was zero
    logic              neg_a;    // sign of quotient a
    logic              neg_b;    // sign of quotient b
    logic [DIV_W-1:0]  num_a;    // dividend magnitude a
    logic [DIV_W-1:0]  num_b;    // dividend magnitude b
    logic [DVS_W-1:0]  den_a;    // divisor magnitude a
    logic [DVS_W-1:0]  den_b;    // divisor magnitude b
    logic [WORD_W-1:0] add_a;    // center added after divide (projection)
    logic [WORD_W-1:0] add_b;
  } cls_word_t;

endpackage

FILE: rtl/pinhole_project_unproject_unit.sv
// ----------------------------------------------------------------------------
// Pinhole projection / unprojection unit
// Projects 3D points to pixels or unprojects pixels to normalized rays.
// ----------------------------------------------------------------------------
// Usage: input words arrive on in_* (valid/ready), one result word per input
// leaves on out_* (valid/ready) in order. in_kind selects projection (0) or
// unprojection (1). Intrinsics sit in four registers written through cfg_*
// (index 0 focal_x, 1 focal_y, 2 center_x, 3 center_y); write them only while
// the unit is idle. Throughput is one word per cycle while out_ready is high.
// A word passes the front registers, the queue and the back; the 64-bit quotient
// comes from a pipelined restoring divider that retires two bits per stage, for
// 32 stages, plus the output register. Reset clears all valid state and loads focal
// lengths of 1.0 and centers of 0. When the receiver holds out_ready low the
// back pipe freezes, the queue fills and then in_ready drops; nothing is lost.
// ----------------------------------------------------------------------------
module pinhole_project_unproject_unit #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_kind,
  input  logic signed [31:0] in_point_x,
  input  logic signed [31:0] in_point_y,
  input  logic signed [31:0] in_point_z,
  input  logic signed [31:0] in_pixel_u,
  input  logic signed [31:0] in_pixel_v,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_res_a,
  output logic signed [31:0] out_res_b,
  output logic signed [31:0] out_res_c,
  output logic               out_saturated,
  output logic               out_div_error
);

  logic [31:0] focal_x_r, focal_y_r, center_x_r, center_y_r;

  // Configuration registers; all four indexes are decoded.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      focal_x_r  <= 32'(1) << FRAC_BITS;
      focal_y_r  <= 32'(1) << FRAC_BITS;
      center_x_r <= '0;
      center_y_r <= '0;
    end else if (cfg_we) begin
      unique case (php_pkg::reg_idx_t'(cfg_index))
        php_pkg::REG_FOCAL_X:  focal_x_r  <= cfg_data;
        php_pkg::REG_FOCAL_Y:  focal_y_r  <= cfg_data;
        php_pkg::REG_CENTER_X: center_x_r <= cfg_data;
        php_pkg::REG_CENTER_Y: center_y_r <= cfg_data;
        default: ;
      endcase
    end
  end

  logic               f_valid, f_ready, q_valid, q_ready;
  php_pkg::cls_word_t f_word, q_word;

  php_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk, .rst_n, .in_valid, .in_ready, .in_kind,
    .in_point_x, .in_point_y, .in_point_z, .in_pixel_u, .in_pixel_v,
    .focal_x(focal_x_r), .focal_y(focal_y_r),
    .center_x(center_x_r), .center_y(center_y_r),
    .cls_valid(f_valid), .cls_ready(f_ready), .cls_word(f_word)
  );

  php_queue u_queue (
    .clk, .rst_n,
    .wr_valid(f_valid), .wr_ready(f_ready), .wr_word(f_word),
    .rd_valid(q_valid), .rd_ready(q_ready), .rd_word(q_word)
  );

  php_back u_back (
    .clk, .rst_n,
    .job_valid(q_valid), .job_ready(q_ready), .job_word(q_word),
    .one_val(32'(1) << FRAC_BITS),
    .out_valid, .out_ready, .out_res_a, .out_res_b, .out_res_c,
    .out_saturated, .out_div_error
  );

endmodule

FILE: rtl/php_front.sv
// ----------------------------------------------------------------------------
// Pinhole front end
// Registers the input word, forms products and differences, and classifies
// each word into a signed division job for the back end.
// ----------------------------------------------------------------------------
module php_front #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic                    in_kind,
  input  logic signed [31:0]      in_point_x,
  input  logic signed [31:0]      in_point_y,
  input  logic signed [31:0]      in_point_z,
  input  logic signed [31:0]      in_pixel_u,
  input  logic signed [31:0]      in_pixel_v,
  input  logic [31:0]             focal_x,
  input  logic [31:0]             focal_y,
  input  logic [31:0]             center_x,
  input  logic [31:0]             center_y,
  output logic                    cls_valid,
  input  logic                    cls_ready,
  output php_pkg::cls_word_t      cls_word
);

  // Stage 1: capture the input word.
  logic              s1_vld_r;
  logic              s1_kind_r;
  logic signed [31:0] s1_a_r, s1_b_r, s1_z_r;
  logic              s1_adv;

  assign s1_adv   = !cls_valid || cls_ready;
  assign in_ready = s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (s1_adv) begin
      s1_vld_r <= in_valid;
    end
    if (s1_adv && in_valid) begin
      s1_kind_r <= in_kind;
      s1_a_r    <= in_kind ? in_pixel_u : in_point_x;
      s1_b_r    <= in_kind ? in_pixel_v : in_point_y;
      s1_z_r    <= in_point_z;
    end
  end

  // Stage 2: one 32x33 product per axis, or a shifted difference.
  logic signed [65:0] prod_a, prod_b, diff_a, diff_b, num_a, num_b;
  logic [65:0]        mag_a, mag_b;
  logic [31:0]        zmag;
  logic               zneg;
  php_pkg::cls_word_t word_nxt;

  always_comb begin
    prod_a = $signed({2'b00, focal_x}) * 66'(s1_a_r);
    prod_b = $signed({2'b00, focal_y}) * 66'(s1_b_r);
    diff_a = (66'(s1_a_r) - $signed({34'd0, center_x})) <<< FRAC_BITS;
    diff_b = (66'(s1_b_r) - $signed({34'd0, center_y})) <<< FRAC_BITS;
    num_a  = s1_kind_r ? diff_a : prod_a;
    num_b  = s1_kind_r ? diff_b : prod_b;
    mag_a  = num_a[65] ? 66'(-num_a) : 66'(num_a);
    mag_b  = num_b[65] ? 66'(-num_b) : 66'(num_b);
    zneg   = s1_z_r[31];
    zmag   = zneg ? 32'(-s1_z_r) : 32'(s1_z_r);
    word_nxt.unproj  = s1_kind_r;
    word_nxt.div_err = s1_kind_r ? (focal_x == '0 || focal_y == '0)
                                 : (s1_z_r == '0);
    word_nxt.neg_a   = num_a[65] ^ (!s1_kind_r && zneg);
    word_nxt.neg_b   = num_b[65] ^ (!s1_kind_r && zneg);
    word_nxt.num_a   = mag_a[63:0];
    word_nxt.num_b   = mag_b[63:0];
    word_nxt.den_a   = s1_kind_r ? focal_x : zmag;
    word_nxt.den_b   = s1_kind_r ? focal_y : zmag;
    word_nxt.add_a   = s1_kind_r ? '0 : center_x;
    word_nxt.add_b   = s1_kind_r ? '0 : center_y;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cls_valid <= 1'b0;
    end else if (s1_adv) begin
      cls_valid <= s1_vld_r;
    end
    if (s1_adv && s1_vld_r) begin
      cls_word <= word_nxt;
    end
  end

endmodule

FILE: rtl/php_queue.sv
// ----------------------------------------------------------------------------
// Pinhole job queue
// Two-entry FIFO between front and back so that each side stalls on its own.
// ----------------------------------------------------------------------------
module php_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               wr_valid,
  output logic               wr_ready,
  input  php_pkg::cls_word_t wr_word,
  output logic               rd_valid,
  input  logic               rd_ready,
  output php_pkg::cls_word_t rd_word
);

  php_pkg::cls_word_t mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       wr_en, rd_en;

  assign wr_ready = cnt_r != 2'd2;
  assign rd_valid = cnt_r != 2'd0;
  assign wr_en    = wr_valid && wr_ready;
  assign rd_en    = rd_valid && rd_ready;
  assign rd_word  = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (wr_en) wp_r <= !wp_r;
      if (rd_en) rp_r <= !rp_r;
      cnt_r <= cnt_r + 2'(wr_en) - 2'(rd_en);
    end
    if (wr_en) mem_r[wp_r] <= wr_word;
  end

  assert property (@(posedge clk) disable iff (!rst_n) cnt_r <= 2'd2)
    else $error("queue count overflow");
  assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'd0 && wr_en) |=> rd_valid)
    else $error("queue lost a word");
  assert property (@(posedge clk) disable iff (!rst_n)
    (wp_r == rp_r) |-> (cnt_r == 2'd0 || cnt_r == 2'd2))
    else $error("queue pointers and count disagree");

endmodule

FILE: rtl/php_back.sv
// ----------------------------------------------------------------------------
// Pinhole back end
// Pipelined restoring divider, two quotient bits per stage for both axes,
// then sign, clamps, center add and saturation into the output register.
// ----------------------------------------------------------------------------
module php_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               job_valid,
  output logic               job_ready,
  input  php_pkg::cls_word_t job_word,
  input  logic [31:0]        one_val,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_res_a,
  output logic signed [31:0] out_res_b,
  output logic signed [31:0] out_res_c,
  output logic               out_saturated,
  output logic               out_div_error
);

  localparam int unsigned NB     = 64;         // quotient bits
  localparam int unsigned PER    = 2;          // bits per stage
  localparam int unsigned NST    = NB / PER;   // divider stages
  localparam int unsigned RW     = 33;         // remainder width

  typedef struct packed {
    logic        unproj, div_err, neg_a, neg_b;
    logic [63:0] na, nb;     // dividend shifting out / quotient shifting in
    logic [RW-1:0] ra, rb;   // partial remainders
    logic [31:0] da, db, ca, cb;
  } dstage_t;

  logic    vld_r [1:NST];
  dstage_t st_r  [1:NST];
  logic    vld0;
  dstage_t st0;
  logic    adv;

  // Whole pipe advances together; output register is the last slot.
  assign adv       = !out_valid || out_ready;
  assign job_ready = adv;

  always_comb begin
    st0.unproj  = job_word.unproj;
    st0.div_err = job_word.div_err;
    st0.neg_a   = job_word.neg_a;
    st0.neg_b   = job_word.neg_b;
    st0.na      = job_word.num_a;
    st0.nb      = job_word.num_b;
    st0.ra      = '0;
    st0.rb      = '0;
    st0.da      = job_word.den_a;
    st0.db      = job_word.den_b;
    st0.ca      = job_word.add_a;
    st0.cb      = job_word.add_b;
    vld0        = job_valid;
  end

  for (genvar s = 0; s < NST; s++) begin : g_div
    dstage_t cur, nx;
    logic    cur_vld;
    if (s == 0) begin : g_head
      assign cur     = st0;
      assign cur_vld = vld0;
    end else begin : g_tail
      assign cur     = st_r[s];
      assign cur_vld = vld_r[s];
    end
    always_comb begin
      logic [RW:0] ta, tb;
      nx = cur;
      for (int k = 0; k < PER; k++) begin
        ta = {nx.ra, nx.na[63]};
        tb = {nx.rb, nx.nb[63]};
        nx.na = {nx.na[62:0], 1'b0};
        nx.nb = {nx.nb[62:0], 1'b0};
        if (ta >= {2'b00, nx.da}) begin
          ta = ta - {2'b00, nx.da};
          nx.na[0] = 1'b1;
        end
        if (tb >= {2'b00, nx.db}) begin
          tb = tb - {2'b00, nx.db};
          nx.nb[0] = 1'b1;
        end
        nx.ra = ta[RW-1:0];
        nx.rb = tb[RW-1:0];
      end
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[s+1] <= 1'b0;
      end else if (adv) begin
        vld_r[s+1] <= cur_vld;
      end
      if (adv) st_r[s+1] <= nx;
    end
  end

  // Finish: sign, clamp (projection only), center add, final clamp.
  localparam logic signed [65:0] MID  = 66'sd1099511627776;
  localparam logic signed [65:0] IMAX = 66'sd2147483647;
  localparam logic signed [65:0] IMIN = -66'sd2147483648;

  dstage_t            fin;
  logic signed [65:0] qa, qb, sa, sb;
  logic               sat_a, sat_b;
  logic signed [31:0] ra_n, rb_n;

  always_comb begin
    fin = st_r[NST];
    qa  = fin.neg_a ? -$signed({2'b00, fin.na}) : $signed({2'b00, fin.na});
    qb  = fin.neg_b ? -$signed({2'b00, fin.nb}) : $signed({2'b00, fin.nb});
    if (!fin.unproj) begin
      if (qa > MID) qa = MID; else if (qa < -MID) qa = -MID;
      if (qb > MID) qb = MID; else if (qb < -MID) qb = -MID;
    end
    sa = qa + $signed({34'd0, fin.ca});
    sb = qb + $signed({34'd0, fin.cb});
    sat_a = (sa > IMAX) || (sa < IMIN);
    sat_b = (sb > IMAX) || (sb < IMIN);
    ra_n = (sa > IMAX) ? 32'sh7fffffff : (sa < IMIN) ? 32'sh80000000 : sa[31:0];
    rb_n = (sb > IMAX) ? 32'sh7fffffff : (sb < IMIN) ? 32'sh80000000 : sb[31:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= vld_r[NST];
    end
    if (adv && vld_r[NST]) begin
      out_div_error <= fin.div_err;
      out_saturated <= !fin.div_err && (sat_a || sat_b);
      out_res_a     <= fin.div_err ? '0 : ra_n;
      out_res_b     <= fin.div_err ? '0 : rb_n;
      out_res_c     <= (fin.div_err || !fin.unproj) ? '0 : one_val;
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_div_error) |-> (out_res_a == '0 && out_res_b == '0
                                      && !out_saturated))
    else $error("div error result not zeroed");
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> out_valid)
    else $error("stalled result dropped");
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> $stable(out_res_a) && $stable(out_res_b))
    else $error("stalled result changed");

endmodule
